>>> src/thel_pkg.sv
// Shared types, constants and the LFSR step function for the touch detector
// with entropy LFSR. No dependencies; imported by every module of the block.
package thel_pkg;

	localparam int WORD_W   = 16;
	localparam int NBITS_W  = 5;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [WORD_W-1:0] LFSR_TAPS     = 16'hB400;
	localparam logic [WORD_W-1:0] LFSR_SEED     = 16'h6d61;
	localparam logic [WORD_W-1:0] LFSR_ALL_ONES = 16'hffff;
	localparam logic [WORD_W-1:0] HIGH_RESET    = 16'd1200;
	localparam logic [WORD_W-1:0] LOW_RESET     = 16'd600;
	localparam logic [NBITS_W-1:0] NBITS_MAX    = 5'd16;

	typedef enum logic [0:0] {
		REG_HIGH_THR = 1'b0,
		REG_LOW_THR  = 1'b1
	} reg_index_t;

	typedef enum logic [0:0] {
		KIND_SENSE = 1'b0,
		KIND_RAND  = 1'b1
	} item_kind_t;

	typedef struct packed {
		logic [WORD_W-1:0] lfsr;
		logic              latch;
	} thel_state_t;

	typedef struct packed {
		logic              touch_event;
		logic [WORD_W-1:0] random_value;
	} thel_result_t;

	function automatic logic [WORD_W-1:0] lfsr_step(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] nxt;
		nxt = s >> 1;
		if (s[0]) begin
			nxt = nxt ^ LFSR_TAPS;
		end
		return nxt;
	endfunction

endpackage

>>> src/thel_core.sv
// Per-item datapath: entropy fold, LFSR advance, touch hysteresis and random
// bit extraction. Depends on thel_pkg.
module thel_core
	import thel_pkg::*;
(
	input  logic                kind,
	input  logic [WORD_W-1:0]   sense_count,
	input  logic [NBITS_W-1:0]  rand_bits,
	input  logic [WORD_W-1:0]   high_threshold,
	input  logic [WORD_W-1:0]   low_threshold,
	input  thel_state_t         cur,
	output thel_state_t         nxt,
	output thel_result_t        res
);

	logic [WORD_W-1:0]  mixed;
	logic [WORD_W-1:0]  two_step;
	logic [NBITS_W-1:0] nbits;
	logic [NBITS_W-1:0] shamt;

	assign mixed    = (sense_count[0] && (cur.lfsr != LFSR_ALL_ONES)) ? ~cur.lfsr : cur.lfsr;
	assign two_step = lfsr_step(lfsr_step(cur.lfsr));
	assign nbits    = (rand_bits > NBITS_MAX) ? NBITS_MAX : rand_bits;
	assign shamt    = NBITS_MAX - nbits;

	always_comb begin
		nxt = cur;
		res = '0;
		case (item_kind_t'(kind))
			KIND_SENSE: begin
				nxt.lfsr = lfsr_step(mixed);
				if (sense_count > high_threshold) begin
					if (!cur.latch) begin
						nxt.latch       = 1'b1;
						res.touch_event = 1'b1;
					end
				end else if (sense_count < low_threshold) begin
					nxt.latch = 1'b0;
				end
			end
			KIND_RAND: begin
				nxt.lfsr = two_step;
				if (nbits != '0) begin
					res.random_value = two_step >> shamt;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

>>> src/touch_hysteresis_with_entropy_lfsr_unit.sv
// Top level of the touch detector with entropy LFSR: input register, datapath
// and result register, plus the APB threshold registers. Depends on thel_pkg, thel_core.
//
// Every beat on the input channel yields exactly one result beat. A sense beat
// folds the low bit of its count into a 16-bit Galois LFSR, advances it once and
// reports a touch once per crossing of high_threshold, re-arming below
// low_threshold; a random beat advances the LFSR twice and returns its top
// rand_bits bits (16 at most). The block takes one beat per cycle while in_stall
// is low: an item is held in the input register, its LFSR and latch update happens in
// the single combinational pass into the result register, and out_valid rises
// when that register is loaded. The result register lets a new beat enter while a
// result waits; in_stall rises only when both registers are full and out_stall
// is high. Thresholds are written through APB at byte addresses 0 (high) and 4
// (low) and should only change while the block is idle.
module touch_hysteresis_with_entropy_lfsr_unit
	import thel_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [WORD_W-1:0]  sense_count,
	input  logic [NBITS_W-1:0] rand_bits,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               touch_event,
	output logic [WORD_W-1:0]  random_value
);

	logic [WORD_W-1:0]  high_thr_q;
	logic [WORD_W-1:0]  low_thr_q;
	thel_state_t        state_q;
	thel_state_t        state_nxt;
	thel_result_t       res_nxt;
	thel_result_t       res_q;
	logic               valid_s1;
	logic               kind_s1;
	logic [WORD_W-1:0]  count_s1;
	logic [NBITS_W-1:0] nbits_s1;
	logic               out_valid_q;
	logic               out_free;
	logic               adv_s1;
	logic               in_take;
	logic               cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign prdata   = (reg_index_t'(paddr[2]) == REG_LOW_THR) ?
			{{(APB_DW-WORD_W){1'b0}}, low_thr_q} : {{(APB_DW-WORD_W){1'b0}}, high_thr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q <= HIGH_RESET;
			low_thr_q  <= LOW_RESET;
		end else if (cfg_wr) begin
			case (reg_index_t'(paddr[2]))
				REG_HIGH_THR: high_thr_q <= pwdata[WORD_W-1:0];
				REG_LOW_THR:  low_thr_q  <= pwdata[WORD_W-1:0];
				default:      high_thr_q <= high_thr_q;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1  <= kind;
			count_s1 <= sense_count;
			nbits_s1 <= rand_bits;
		end
	end

	thel_core u_core (
		.kind           (kind_s1),
		.sense_count    (count_s1),
		.rand_bits      (nbits_s1),
		.high_threshold (high_thr_q),
		.low_threshold  (low_thr_q),
		.cur            (state_q),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.lfsr  <= LFSR_SEED;
			state_q.latch <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign touch_event  = res_q.touch_event;
	assign random_value = res_q.random_value;

endmodule

>>> src/thel_checker.sv
// Port-level checks for touch_hysteresis_with_entropy_lfsr_unit, attached by bind.
// Depends on thel_pkg.
module thel_checker
	import thel_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              touch_event,
	input logic [WORD_W-1:0] random_value
);

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(touch_event && (random_value != '0)))
		else $error("touch and random value in one beat");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty result register");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(random_value) && $stable(touch_event))
		else $error("stalled result beat changed");

	a_stall_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_stall)
		else $error("input stalled while output drains");

endmodule

bind touch_hysteresis_with_entropy_lfsr_unit thel_checker u_thel_checker (.*);

>>> tb/touch_lfsr_checker.sv
// Checker for touch_hysteresis_with_entropy_lfsr_unit: tracks the APB threshold writes
// and the input beats, predicts every result and compares it with the output channel.
// Depends on thel_pkg.
module touch_lfsr_checker
	import thel_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               kind,
	input  logic [WORD_W-1:0]  sense_count,
	input  logic [NBITS_W-1:0] rand_bits,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               touch_event,
	input  logic [WORD_W-1:0]  random_value,
	output int                 mismatches,
	output int                 open_beats
);

	logic [WORD_W-1:0] high_thr;
	logic [WORD_W-1:0] low_thr;
	logic [WORD_W-1:0] lfsr_copy;
	logic              touched;
	thel_result_t      due_results[$];
	thel_result_t      want;
	int                result_no;

	function automatic logic [WORD_W-1:0] galois_shift(input logic [WORD_W-1:0] v);
		return (v >> 1) ^ (v[0] ? LFSR_TAPS : '0);
	endfunction

	function automatic thel_result_t sense_or_draw(input logic k, input logic [WORD_W-1:0] cnt,
			input logic [NBITS_W-1:0] nb);
		thel_result_t r;
		int width;
		r = '0;
		if (item_kind_t'(k) == KIND_SENSE) begin
			if (cnt[0] && lfsr_copy != LFSR_ALL_ONES) begin
				lfsr_copy = ~lfsr_copy;
			end
			lfsr_copy = galois_shift(lfsr_copy);
			if (cnt > high_thr) begin
				r.touch_event = !touched;
				touched = 1'b1;
			end else if (cnt < low_thr) begin
				touched = 1'b0;
			end
		end else begin
			lfsr_copy = galois_shift(galois_shift(lfsr_copy));
			width = (nb > WORD_W) ? WORD_W : int'(nb);
			if (width != 0) begin
				r.random_value = lfsr_copy >> (WORD_W - width);
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr = HIGH_RESET;
			low_thr = LOW_RESET;
			lfsr_copy = LFSR_SEED;
			touched = 1'b0;
			due_results.delete();
			result_no = 0;
			mismatches = 0;
			open_beats <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[APB_AW-1:2]))
					REG_HIGH_THR: high_thr = pwdata[WORD_W-1:0];
					REG_LOW_THR: low_thr = pwdata[WORD_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				due_results.push_back(sense_or_draw(kind, sense_count, rand_bits));
			end
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					if (mismatches < 10) begin
						$display("result %0d: no beat pending, got touch %0b value %h",
							result_no, touch_event, random_value);
					end
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (want.touch_event !== touch_event || want.random_value !== random_value) begin
						if (mismatches < 10) begin
							$display("result %0d: expected touch %0b value %h, got touch %0b value %h",
								result_no, want.touch_event, want.random_value,
								touch_event, random_value);
						end
						mismatches++;
					end
				end
				result_no++;
			end
			open_beats <= due_results.size();
		end
	end

endmodule

>>> tb/testbench.sv
// Top of the touch detector testbench: clock, reset, APB threshold writes, input
// beats and output stalls, watchdog and verdict. Depends on thel_pkg, the block
// and touch_lfsr_checker.
module testbench;
	import thel_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 200;
	localparam int PHASE_BEATS    = 100;
	localparam int PHASES         = 7;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic               kind;
	logic [WORD_W-1:0]  sense_count;
	logic [NBITS_W-1:0] rand_bits;
	logic               out_valid;
	logic               out_stall;
	logic               touch_event;
	logic [WORD_W-1:0]  random_value;

	int                 mismatches;
	int                 open_beats;
	int                 idle_cycles = 0;
	bit                 hold_off = 1'b0;
	bit                 tx_calm = 1'b0;
	bit                 rx_calm = 1'b0;
	logic [WORD_W-1:0]  hi_now;
	logic [WORD_W-1:0]  lo_now;

	touch_hysteresis_with_entropy_lfsr_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind),
		.sense_count(sense_count), .rand_bits(rand_bits),
		.out_valid(out_valid), .out_stall(out_stall),
		.touch_event(touch_event), .random_value(random_value)
	);

	touch_lfsr_checker watch (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind),
		.sense_count(sense_count), .rand_bits(rand_bits),
		.out_valid(out_valid), .out_stall(out_stall),
		.touch_event(touch_event), .random_value(random_value),
		.mismatches(mismatches), .open_beats(open_beats)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_beat(input logic k, input logic [WORD_W-1:0] c,
			input logic [NBITS_W-1:0] n);
		int gap;
		in_valid <= 1'b1;
		kind <= k;
		sense_count <= c;
		rand_bits <= n;
		do @(posedge clk); while (in_stall);
		gap = (tx_calm || hold_off) ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (open_beats == 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [WORD_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DW'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_thresholds(input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] lo);
		drain();
		write_reg(REG_HIGH_THR, hi);
		write_reg(REG_LOW_THR, lo);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		hi_now = hi;
		lo_now = lo;
		@(posedge clk);
	endtask

	initial begin
		int len;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else if (rx_calm) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 99) < 45);
				len = pick_gap() + 1;
				repeat (len) @(posedge clk);
			end
		end
	end

	initial begin
		int steer;
		int v;
		logic [WORD_W-1:0] s;
		logic [WORD_W-1:0] c;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		kind <= KIND_SENSE;
		sense_count <= '0;
		rand_bits <= '0;
		hi_now = HIGH_RESET;
		lo_now = LOW_RESET;

		// find the entropy bits that walk the seed into the all-ones state
		steer = 0;
		for (int p = 65535; p >= 0; p--) begin
			s = LFSR_SEED;
			for (int i = 0; i < 16; i++) begin
				if (p[i] && s != LFSR_ALL_ONES) s = ~s;
				s = lfsr_step(s);
			end
			if (s == LFSR_ALL_ONES) steer = p;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 16; i++) begin
			c = (i % 4 == 3) ? 16'd100 : (i % 4 == 2) ? 16'd900 : 16'd2000;
			send_beat(KIND_SENSE, c | WORD_W'(steer[i]), NBITS_W'($urandom));
		end
		send_beat(KIND_SENSE, 16'hffff, NBITS_W'($urandom));
		send_beat(KIND_SENSE, 16'd600, 5'd0);
		send_beat(KIND_SENSE, 16'd599, 5'd31);
		send_beat(KIND_SENSE, 16'd1200, 5'd16);
		send_beat(KIND_SENSE, 16'd1201, 5'd1);
		send_beat(KIND_SENSE, 16'd0, 5'd17);
		send_beat(KIND_RAND, 16'hffff, 5'd0);
		send_beat(KIND_RAND, 16'h0000, 5'd1);
		send_beat(KIND_RAND, 16'h5555, 5'd16);
		send_beat(KIND_RAND, 16'haaaa, 5'd17);
		send_beat(KIND_RAND, 16'h0001, 5'd31);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_thresholds(16'hffff, 16'h0000);
				1: set_thresholds(16'h0000, 16'hffff);
				2: set_thresholds(16'h0000, 16'h0000);
				3: set_thresholds(16'hffff, 16'hffff);
				4: set_thresholds(16'd3000, 16'd1000);
				default: set_thresholds(WORD_W'($urandom), WORD_W'($urandom));
			endcase
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_BEATS; k++) begin
				if (phase == 4 && k == 20) hold_off = 1'b1;
				if ($urandom_range(0, 99) < 35) begin
					send_beat(KIND_RAND, WORD_W'($urandom), NBITS_W'($urandom_range(0, 31)));
				end else begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: v = $urandom_range(0, 65535);
						4, 5, 6: v = int'(hi_now) + int'($urandom_range(0, 8)) - 4;
						7, 8: v = int'(lo_now) + int'($urandom_range(0, 8)) - 4;
						default: v = ($urandom_range(0, 1) == 1) ? 65535 : 0;
					endcase
					if (v < 0) v = 0;
					if (v > 65535) v = 65535;
					send_beat(KIND_SENSE, WORD_W'(v), NBITS_W'($urandom));
				end
			end
		end

		drain();
		if (mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

>>> files.f
src/thel_pkg.sv
src/thel_core.sv
src/touch_hysteresis_with_entropy_lfsr_unit.sv
src/thel_checker.sv
tb/touch_lfsr_checker.sv
tb/testbench.sv
